// File: sv/tfb_pkg.sv
// Shared types and constants of the text frame buffer and panel streamer.
package tfb_pkg;

    // One input word as it arrives on the request channel.
    typedef struct packed {
        logic [1:0]  req_type;
        logic        line_sel;
        logic [7:0]  char_code;
        logic [11:0] font_addr;
        logic [7:0]  font_byte;
    } tfb_in_t;

    // One output word as it leaves toward the panel.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_end;
    } tfb_out_t;

    // Operation that the front hands to the back through the queue.
    typedef enum logic [1:0] {
        OP_START,
        OP_CHAR,
        OP_REFRESH,
        OP_FONT
    } tfb_op_t;

    // Back status seen by the front and the top level.
    typedef struct packed {
        logic clearing;
        logic busy;
    } tfb_status_t;

    // Request type codes.
    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_CHAR    = 2'd1;
    localparam logic [1:0] REQ_REFRESH = 2'd2;
    localparam logic [1:0] REQ_FONT    = 2'd3;

    // First printable character code held in the font.
    localparam int FIRST_CODE = 32;

    // Panel command bytes sent ahead of each page.
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;

endpackage

// File: sv/tfb_front.sv
// Request front end: accepts words, drops ignored ones, builds queue commands.
module tfb_front #(
    parameter int GLYPH_COUNT = 95,
    parameter int GLYPH_BYTES = 25,
    parameter int FA_W        = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tfb_pkg::tfb_in_t     s_data,
    input  tfb_pkg::tfb_status_t status,
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic [2+1+FA_W+8-1:0] q_cmd
);

    localparam int FONT_SIZE = GLYPH_COUNT * GLYPH_BYTES;

    typedef struct packed {
        tfb_pkg::tfb_op_t  op;
        logic              line;
        logic [FA_W-1:0]   addr;
        logic [7:0]        data;
    } cmd_t;

    logic        valid_reg, valid_next;
    cmd_t        cmd_reg, cmd_next;
    cmd_t        cmd_c;
    logic        keep_c;
    logic        take;
    logic [31:0] addr_wide;
    logic [31:0] glyph_idx;
    logic [31:0] glyph_base;
    logic        code_ok;

    assign addr_wide  = 32'(s_data.font_addr);
    assign glyph_idx  = 32'(s_data.char_code) - 32'(tfb_pkg::FIRST_CODE);
    assign glyph_base = glyph_idx * 32'(GLYPH_BYTES);
    assign code_ok    = (32'(s_data.char_code) >= 32'(tfb_pkg::FIRST_CODE)) &&
                        (32'(s_data.char_code) < 32'(tfb_pkg::FIRST_CODE + GLYPH_COUNT));

    // Classify the word and drop what has no effect.
    always_comb begin
        cmd_c.line = s_data.line_sel;
        cmd_c.data = s_data.font_byte;
        cmd_c.addr = addr_wide[FA_W-1:0];
        cmd_c.op   = tfb_pkg::OP_START;
        keep_c     = 1'b1;
        unique case (s_data.req_type)
            tfb_pkg::REQ_START: begin
                cmd_c.op = tfb_pkg::OP_START;
            end
            tfb_pkg::REQ_CHAR: begin
                cmd_c.op   = tfb_pkg::OP_CHAR;
                cmd_c.addr = glyph_base[FA_W-1:0];
                keep_c     = code_ok;
            end
            tfb_pkg::REQ_REFRESH: begin
                cmd_c.op = tfb_pkg::OP_REFRESH;
            end
            tfb_pkg::REQ_FONT: begin
                cmd_c.op = tfb_pkg::OP_FONT;
                keep_c   = addr_wide < 32'(FONT_SIZE);
            end
            default: begin
                keep_c = 1'b0;
            end
        endcase
    end

    assign s_ready = !status.clearing && (!valid_reg || q_ready);
    assign take    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg && !q_ready;
        cmd_next   = cmd_reg;
        if (take) begin
            valid_next = keep_c;
            cmd_next   = cmd_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign q_valid = valid_reg;
    assign q_cmd   = cmd_reg;

endmodule

// File: sv/tfb_fifo.sv
// Short command queue between the front end and the back end.
module tfb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: sv/tfb_back.sv
// Command back end: font store, two frame banks, glyph copy and refresh stream.
module tfb_back #(
    parameter int COLUMNS       = 128,
    parameter int PAGES         = 4,
    parameter int GLYPH_COUNT   = 95,
    parameter int GLYPH_BYTES   = 25,
    parameter int GLYPH_COLUMNS = 12,
    parameter int FA_W          = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  logic [2+1+FA_W+8-1:0] q_cmd,
    output tfb_pkg::tfb_status_t  status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tfb_pkg::tfb_out_t     m_data
);

    localparam int FONT_SIZE  = GLYPH_COUNT * GLYPH_BYTES;
    localparam int HALF_PAGES = (PAGES + 1) / 2;
    localparam int ROW_W      = (HALF_PAGES > 1) ? $clog2(HALF_PAGES) : 1;
    localparam int BANK_ROWS  = 1 << ROW_W;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int CUR_W      = $clog2(COLUMNS + 1);
    localparam int CW         = CUR_W + 1;
    localparam int SUM_W      = ((CUR_W > 8) ? CUR_W : 8) + 1;
    localparam int ST_W       = $clog2(GLYPH_COLUMNS + 1);
    localparam int PG_W       = $clog2(PAGES);
    localparam int K_W        = $clog2(COLUMNS + 3);
    localparam int K_COL_LOW  = 0;
    localparam int K_COL_HIGH = 1;
    localparam int K_PAGE     = 2;
    localparam int K_LAST     = COLUMNS + 2;
    localparam bit LOWER_LINE0_OK = PAGES > 1;
    localparam bit UPPER_LINE1_OK = PAGES > 2;
    localparam bit LOWER_LINE1_OK = PAGES > 3;

    typedef struct packed {
        tfb_pkg::tfb_op_t  op;
        logic              line;
        logic [FA_W-1:0]   addr;
        logic [7:0]        data;
    } cmd_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHAR,
        S_REF
    } state_t;

    cmd_t cmd;
    assign cmd = q_cmd;

    // Stores.
    logic [7:0] font_mem [FONT_SIZE];
    logic [7:0] even_mem [BANK_ROWS][COLUMNS];
    logic [7:0] odd_mem  [BANK_ROWS][COLUMNS];

    // Registers.
    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  clr_row_reg, clr_row_next;
    logic [COL_W-1:0]  clr_col_reg, clr_col_next;
    logic [CUR_W-1:0]  cur0_reg, cur0_next;
    logic [CUR_W-1:0]  cur1_reg, cur1_next;
    logic              line_reg, line_next;
    logic [FA_W-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [ST_W-1:0]   step_reg, step_next;
    logic [7:0]        width_reg, width_next;
    logic [PG_W-1:0]   ref_page_reg, ref_page_next;
    logic [K_W-1:0]    ref_k_reg, ref_k_next;
    logic              ref_odd_reg, ref_odd_next;
    logic              ref_last_reg, ref_last_next;
    logic              m_valid_reg, m_valid_next;
    tfb_pkg::tfb_out_t m_data_reg, m_data_next;
    logic [7:0]        font_qa_reg, font_qb_reg;
    logic [7:0]        fr_even_q_reg, fr_odd_q_reg;

    // Store ports.
    logic              font_we, font_re;
    logic [FA_W-1:0]   font_wa, font_ra, font_rb;
    logic [7:0]        font_wd;
    logic              ev_we, od_we;
    logic [ROW_W-1:0]  fw_row;
    logic [COL_W-1:0]  fw_col;
    logic [7:0]        ev_wd, od_wd;
    logic              fr_re;
    logic [ROW_W-1:0]  fr_row;
    logic [COL_W-1:0]  fr_col;

    logic              out_free;
    logic              col_ok;
    logic [CUR_W-1:0]  cur_sel;
    logic [SUM_W-1:0]  cur_sum;
    logic [CUR_W-1:0]  cur_new;
    logic              ref_page_last;

    assign out_free      = !m_valid_reg || m_ready;
    assign col_ok        = col_reg < CW'(COLUMNS);
    assign cur_sel       = line_reg ? cur1_reg : cur0_reg;
    assign cur_sum       = SUM_W'(cur_sel) + SUM_W'(width_reg);
    assign cur_new       = (cur_sum > SUM_W'(COLUMNS)) ? CUR_W'(COLUMNS) : cur_sum[CUR_W-1:0];
    assign ref_page_last = ref_page_reg == PG_W'(PAGES - 1);

    always_comb begin
        state_next    = state_reg;
        clr_row_next  = clr_row_reg;
        clr_col_next  = clr_col_reg;
        cur0_next     = cur0_reg;
        cur1_next     = cur1_reg;
        line_next     = line_reg;
        ptr_next      = ptr_reg;
        col_next      = col_reg;
        step_next     = step_reg;
        width_next    = width_reg;
        ref_page_next = ref_page_reg;
        ref_k_next    = ref_k_reg;
        ref_odd_next  = ref_odd_reg;
        ref_last_next = ref_last_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        q_ready       = 1'b0;
        font_we       = 1'b0;
        font_wa       = cmd.addr;
        font_wd       = cmd.data;
        font_re       = 1'b0;
        font_ra       = ptr_reg;
        font_rb       = ptr_reg + 1'b1;
        ev_we         = 1'b0;
        od_we         = 1'b0;
        fw_row        = ROW_W'(line_reg);
        fw_col        = col_reg[COL_W-1:0];
        ev_wd         = font_qa_reg;
        od_wd         = font_qb_reg;
        fr_re         = 1'b0;
        fr_row        = ROW_W'(ref_page_reg >> 1);
        fr_col        = COL_W'(ref_k_reg - K_W'(3));

        unique case (state_reg)
            S_CLEAR: begin
                ev_we  = 1'b1;
                od_we  = 1'b1;
                fw_row = clr_row_reg;
                fw_col = clr_col_reg;
                ev_wd  = '0;
                od_wd  = '0;
                if (clr_col_reg == COL_W'(COLUMNS - 1)) begin
                    clr_col_next = '0;
                    clr_row_next = clr_row_reg + 1'b1;
                    if (clr_row_reg == ROW_W'(BANK_ROWS - 1)) begin
                        state_next = S_IDLE;
                    end
                end else begin
                    clr_col_next = clr_col_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (q_valid && (cmd.op != tfb_pkg::OP_REFRESH || out_free)) begin
                    q_ready = 1'b1;
                    unique case (cmd.op)
                        tfb_pkg::OP_START: begin
                            if (cmd.line) begin
                                cur1_next = '0;
                            end else begin
                                cur0_next = '0;
                            end
                        end
                        tfb_pkg::OP_FONT: begin
                            font_we = 1'b1;
                        end
                        tfb_pkg::OP_CHAR: begin
                            font_re    = 1'b1;
                            font_ra    = cmd.addr;
                            line_next  = cmd.line;
                            ptr_next   = cmd.addr + 1'b1;
                            col_next   = CW'(cmd.line ? cur1_reg : cur0_reg);
                            step_next  = '0;
                            state_next = S_CHAR;
                        end
                        tfb_pkg::OP_REFRESH: begin
                            if (ref_k_reg == K_W'(K_LAST)) begin
                                ref_k_next    = '0;
                                ref_page_next = ref_page_last ? '0 : ref_page_reg + 1'b1;
                            end else begin
                                ref_k_next = ref_k_reg + 1'b1;
                            end
                            m_data_next.is_data   = 1'b0;
                            m_data_next.frame_end = 1'b0;
                            if (ref_k_reg == K_W'(K_COL_LOW)) begin
                                m_valid_next         = 1'b1;
                                m_data_next.out_byte = tfb_pkg::CMD_COL_LOW;
                            end else if (ref_k_reg == K_W'(K_COL_HIGH)) begin
                                m_valid_next         = 1'b1;
                                m_data_next.out_byte = tfb_pkg::CMD_COL_HIGH;
                            end else if (ref_k_reg == K_W'(K_PAGE)) begin
                                m_valid_next         = 1'b1;
                                m_data_next.out_byte = tfb_pkg::CMD_PAGE_BASE +
                                                       8'(ref_page_reg);
                            end else begin
                                fr_re         = 1'b1;
                                ref_odd_next  = ref_page_reg[0];
                                ref_last_next = ref_page_last &&
                                                (ref_k_reg == K_W'(K_LAST));
                                state_next    = S_REF;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHAR: begin
                // Step zero sees the width byte; later steps see a column pair.
                if (step_reg == '0) begin
                    width_next = font_qa_reg;
                end else begin
                    ev_we    = col_ok && (!line_reg || UPPER_LINE1_OK);
                    od_we    = col_ok && (line_reg ? LOWER_LINE1_OK : LOWER_LINE0_OK);
                    col_next = col_reg + 1'b1;
                end
                if (step_reg < ST_W'(GLYPH_COLUMNS)) begin
                    font_re   = 1'b1;
                    ptr_next  = ptr_reg + FA_W'(2);
                    step_next = step_reg + 1'b1;
                end else begin
                    if (line_reg) begin
                        cur1_next = cur_new;
                    end else begin
                        cur0_next = cur_new;
                    end
                    state_next = S_IDLE;
                end
            end
            S_REF: begin
                m_valid_next          = 1'b1;
                m_data_next.out_byte  = ref_odd_reg ? fr_odd_q_reg : fr_even_q_reg;
                m_data_next.is_data   = 1'b1;
                m_data_next.frame_end = ref_last_reg;
                state_next            = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_row_reg  <= '0;
            clr_col_reg  <= '0;
            cur0_reg     <= '0;
            cur1_reg     <= '0;
            ref_page_reg <= '0;
            ref_k_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_row_reg  <= clr_row_next;
            clr_col_reg  <= clr_col_next;
            cur0_reg     <= cur0_next;
            cur1_reg     <= cur1_next;
            ref_page_reg <= ref_page_next;
            ref_k_reg    <= ref_k_next;
            m_valid_reg  <= m_valid_next;
        end
        line_reg     <= line_next;
        ptr_reg      <= ptr_next;
        col_reg      <= col_next;
        step_reg     <= step_next;
        width_reg    <= width_next;
        ref_odd_reg  <= ref_odd_next;
        ref_last_reg <= ref_last_next;
        m_data_reg   <= m_data_next;
    end

    // Font store: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (font_we) begin
            font_mem[font_wa] <= font_wd;
        end
        if (font_re) begin
            font_qa_reg <= font_mem[font_ra];
            font_qb_reg <= font_mem[font_rb];
        end
    end

    // Frame banks: even pages and odd pages, written at one address, read together.
    always_ff @(posedge aclk) begin
        if (ev_we) begin
            even_mem[fw_row][fw_col] <= ev_wd;
        end
        if (od_we) begin
            odd_mem[fw_row][fw_col] <= od_wd;
        end
        if (fr_re) begin
            fr_even_q_reg <= even_mem[fr_row][fr_col];
            fr_odd_q_reg  <= odd_mem[fr_row][fr_col];
        end
    end

    assign status.clearing = state_reg == S_CLEAR;
    assign status.busy     = (state_reg == S_CHAR) || (state_reg == S_REF);
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;

endmodule

// File: sv/text_frame_buffer_lcd_streamer_unit.sv
// Top level of the text frame buffer with page-mode panel streamer.
//
//  channel | direction | handshake          | word type
//  --------+-----------+--------------------+-------------------
//  s_      | in        | s_valid / s_ready  | tfb_pkg::tfb_in_t
//  m_      | out       | m_valid / m_ready  | tfb_pkg::tfb_out_t
//
// Back end: start-line and font-load words are done in S_IDLE; a character reads
// its width byte, then one column pair per step in S_CHAR; a refresh command byte
// is sent from S_IDLE, a data byte is read from a bank and sent from S_REF; the
// front register and the queue lie ahead of the back. Reset: a clearing pass
// zeroes the frame banks one column a cycle, with s_ready low.
// Stalls: a four-entry queue decouples front and back; refresh waits on m_ready.
module text_frame_buffer_lcd_streamer_unit #(
    parameter int COLUMNS       = 128,
    parameter int PAGES         = 4,
    parameter int GLYPH_COUNT   = 95,
    parameter int GLYPH_BYTES   = 25,
    parameter int GLYPH_COLUMNS = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tfb_pkg::tfb_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tfb_pkg::tfb_out_t m_data
);

    localparam int FONT_SIZE   = GLYPH_COUNT * GLYPH_BYTES;
    localparam int FA_W        = $clog2(FONT_SIZE);
    localparam int CMD_W       = 2 + 1 + FA_W + 8;
    localparam int QUEUE_DEPTH = 4;

    tfb_pkg::tfb_status_t status;
    logic                 fq_valid, fq_ready;
    logic [CMD_W-1:0]     fq_cmd;
    logic                 qb_valid, qb_ready;
    logic [CMD_W-1:0]     qb_cmd;

    // Accept and classify words; hold them while the queue is full.
    tfb_front #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_BYTES (GLYPH_BYTES),
        .FA_W        (FA_W)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .status  (status),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_cmd   (fq_cmd)
    );

    // Buffer commands so the front and back stall independently.
    tfb_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_cmd)
    );

    // Execute commands against the stores and drive the output register.
    tfb_back #(
        .COLUMNS       (COLUMNS),
        .PAGES         (PAGES),
        .GLYPH_COUNT   (GLYPH_COUNT),
        .GLYPH_BYTES   (GLYPH_BYTES),
        .GLYPH_COLUMNS (GLYPH_COLUMNS),
        .FA_W          (FA_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_cmd   (qb_cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef SYNTHESIS
    // Frame end marks a data byte, never a command byte.
    a_end_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_end |-> m_data.is_data)
        else $error("frame_end raised on a command word");

    // Keep the back quiet while the frame banks are being cleared.
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !m_valid && !status.busy && !qb_ready)
        else $error("back end active during clearing pass");
`endif

endmodule
